[rtl/jda_pkg.sv]
// jda_pkg: shared types, constants and a helper function for the jet dipolarity block.
// Used by jda_ctrl, jda_datapath and jet_dipolarity_accumulator through scoped names.
`default_nettype none

package jda_pkg;

    // input mode codes
    localparam logic [1:0] MODE_AXIS_ONE = 2'd0;
    localparam logic [1:0] MODE_AXIS_TWO = 2'd1;
    localparam logic [1:0] MODE_CONST    = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CLOSE   = 2'd1;
    localparam logic [1:0] STATUS_ZERO_PT = 2'd2;

    // fixed point: angles in 2^-12 units
    localparam logic signed [16:0] PI_Q     = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q = 17'sd25736;
    localparam logic [33:0] CLOSE_LIMIT_Q   = 34'd16778;
    localparam logic [23:0] VALUE_MAX       = 24'hFFFFFF;

    localparam int DIV_STEPS  = 34;
    localparam int FDIV_STEPS = 24;

    // which part of the axis segment a constituent projects onto
    typedef enum logic [1:0] {
        BR_AXIS_ONE = 2'd0,
        BR_PERP     = 2'd1,
        BR_AXIS_TWO = 2'd2
    } t_branch;

    typedef struct packed {
        logic load_ax1;
        logic load_ax2;
        logic capture;
        logic calc_diff;
        logic calc_prod;
        logic calc_sum;
        logic calc_sel;
        logic calc_csq;
        logic div_init;
        logic div_step;
        logic calc_wmul;
        logic acc_add;
        logic fin_mul;
        logic fin_sum;
        logic fdiv_init;
        logic fdiv_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_branch branch;
        logic    out_free;
    } t_dp_stat;

    // wrap a phi difference into (-pi, pi]
    function automatic logic signed [16:0] wrap_dphi(input logic signed [16:0] d);
        logic signed [16:0] r;
        r = d;
        if (d > PI_Q) begin
            r = d - TWO_PI_Q;
        end else if (d <= -PI_Q) begin
            r = d + TWO_PI_Q;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/jda_datapath.sv]
// jda_datapath: axis registers, geometry products, two restoring dividers and accumulators.
// Driven by jda_ctrl command strobes; uses jda_pkg.
`default_nettype none

module jda_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire jda_pkg::t_dp_cmd   i_cmd,
    output jda_pkg::t_dp_stat       o_stat,
    input  wire logic signed [15:0] i_eta,
    input  wire logic signed [14:0] i_phi,
    input  wire logic [19:0]        i_pt,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic [23:0]             o_dipolarity_value,
    output logic [1:0]              o_status
);

    logic signed [15:0] r_a1e, r_a2e, r_eta;
    logic signed [14:0] r_a1p, r_a2p, r_phi;
    logic [19:0]        r_pt;

    logic signed [16:0] r_dx, r_dy, r_ex, r_ey, r_ax, r_ay;
    logic signed [33:0] r_pdxax, r_pdyay, r_pdxay, r_pdyax;
    logic [33:0]        r_sdx, r_sdy, r_sex, r_sey, r_sax, r_say;
    logic signed [34:0] r_dot, r_cross;
    logic [33:0]        r_m12, r_d1, r_d2e, r_d2;
    logic [30:0]        r_cabs;
    logic [61:0]        r_csq;
    logic [34:0]        r_rem;
    logic [33:0]        r_dlo;
    logic [53:0]        r_w;
    logic [61:0]        r_wsum;
    logic [27:0]        r_ptt;
    logic [44:0]        r_pp_lo, r_pp_hi;
    logic [61:0]        r_den, r_frem;
    logic [23:0]        r_flo, r_q;
    logic               r_fsat;
    logic               r_out_valid;
    logic [23:0]        r_out_value;
    logic [1:0]         r_out_status;

    jda_pkg::t_branch   branch;
    logic [35:0]        div_t;
    logic               div_ge;
    logic [62:0]        fdiv_t;
    logic               fdiv_ge;
    logic [62:0]        wsum_sum;
    logic [28:0]        ptt_sum;
    logic               close;

    always_comb begin
        if (r_dot[34]) begin
            branch = jda_pkg::BR_AXIS_ONE;
        end else if (r_m12 != '0 && r_dot < 35'(r_m12)) begin
            branch = jda_pkg::BR_PERP;
        end else begin
            branch = jda_pkg::BR_AXIS_TWO;
        end
    end

    assign div_t    = {r_rem, r_dlo[33]};
    assign div_ge   = div_t >= 36'(r_m12);
    assign fdiv_t   = {r_frem, r_flo[23]};
    assign fdiv_ge  = fdiv_t >= {1'b0, r_den};
    assign wsum_sum = {1'b0, r_wsum} + 63'(r_w);
    assign ptt_sum  = {1'b0, r_ptt} + 29'(r_pt);
    assign close    = r_m12 < jda_pkg::CLOSE_LIMIT_Q;

    assign o_stat.branch   = branch;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // control state: axes, accumulators, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1e       <= '0;
            r_a1p       <= '0;
            r_a2e       <= '0;
            r_a2p       <= '0;
            r_wsum      <= '0;
            r_ptt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_ax1) begin
                r_a1e <= i_eta;
                r_a1p <= i_phi;
            end
            if (i_cmd.load_ax2) begin
                r_a2e <= i_eta;
                r_a2p <= i_phi;
            end
            if (i_cmd.acc_add) begin
                r_wsum <= wsum_sum[62] ? '1 : wsum_sum[61:0];
                r_ptt  <= ptt_sum[28] ? '1 : ptt_sum[27:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_wsum      <= '0;
                r_ptt       <= '0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_eta <= i_eta;
            r_phi <= i_phi;
            r_pt  <= i_pt;
        end
        if (i_cmd.calc_diff) begin
            r_dx <= 17'(r_eta) - 17'(r_a1e);
            r_ex <= 17'(r_eta) - 17'(r_a2e);
            r_ax <= 17'(r_a2e) - 17'(r_a1e);
            r_dy <= jda_pkg::wrap_dphi(17'(r_phi) - 17'(r_a1p));
            r_ey <= jda_pkg::wrap_dphi(17'(r_phi) - 17'(r_a2p));
            r_ay <= jda_pkg::wrap_dphi(17'(r_a2p) - 17'(r_a1p));
        end
        if (i_cmd.calc_prod) begin
            r_pdxax <= r_dx * r_ax;
            r_pdyay <= r_dy * r_ay;
            r_pdxay <= r_dx * r_ay;
            r_pdyax <= r_dy * r_ax;
            r_sdx   <= 34'(r_dx * r_dx);
            r_sdy   <= 34'(r_dy * r_dy);
            r_sex   <= 34'(r_ex * r_ex);
            r_sey   <= 34'(r_ey * r_ey);
            r_sax   <= 34'(r_ax * r_ax);
            r_say   <= 34'(r_ay * r_ay);
        end
        if (i_cmd.calc_sum) begin
            r_dot   <= 35'(r_pdxax) + 35'(r_pdyay);
            r_cross <= 35'(r_pdxay) - 35'(r_pdyax);
            r_m12   <= r_sax + r_say;
            r_d1    <= r_sdx + r_sdy;
            r_d2e   <= r_sex + r_sey;
        end
        if (i_cmd.calc_sel) begin
            r_d2   <= (branch == jda_pkg::BR_AXIS_ONE) ? r_d1 : r_d2e;
            r_cabs <= r_cross[34] ? 31'(-r_cross) : 31'(r_cross);
        end
        if (i_cmd.calc_csq) begin
            r_csq <= r_cabs * r_cabs;
        end
        // perpendicular distance: cross^2 / m12, quotient known to fit 34 bits
        if (i_cmd.div_init) begin
            r_rem <= 35'(r_csq[61:34]);
            r_dlo <= r_csq[33:0];
            r_d2  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? 35'(div_t - 36'(r_m12)) : div_t[34:0];
            r_dlo <= {r_dlo[32:0], 1'b0};
            r_d2  <= {r_d2[32:0], div_ge};
        end
        if (i_cmd.calc_wmul) begin
            r_w <= r_pt * r_d2;
        end
        // denominator pt_total * m12 in two partial products
        if (i_cmd.fin_mul) begin
            r_pp_lo <= r_ptt * r_m12[16:0];
            r_pp_hi <= r_ptt * r_m12[33:17];
        end
        if (i_cmd.fin_sum) begin
            r_den <= 62'(r_pp_lo) + (62'(r_pp_hi) << 17);
        end
        if (i_cmd.fdiv_init) begin
            r_fsat <= 62'(r_wsum[61:8]) >= r_den;
            r_frem <= 62'(r_wsum[61:8]);
            r_flo  <= {r_wsum[7:0], 16'h0000};
            r_q    <= '0;
        end
        if (i_cmd.fdiv_step) begin
            r_frem <= fdiv_ge ? 62'(fdiv_t - {1'b0, r_den}) : fdiv_t[61:0];
            r_flo  <= {r_flo[22:0], 1'b0};
            r_q    <= {r_q[22:0], fdiv_ge};
        end
        if (i_cmd.out_load) begin
            if (close) begin
                r_out_value  <= '0;
                r_out_status <= jda_pkg::STATUS_CLOSE;
            end else if (r_ptt == '0) begin
                r_out_value  <= '0;
                r_out_status <= jda_pkg::STATUS_ZERO_PT;
            end else begin
                r_out_value  <= r_fsat ? jda_pkg::VALUE_MAX : r_q;
                r_out_status <= jda_pkg::STATUS_OK;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_dipolarity_value = r_out_value;
    assign o_status           = r_out_status;

endmodule

`default_nettype wire

[rtl/jda_ctrl.sv]
// jda_ctrl: sequencer for the jet dipolarity block, with constituent count.
// Issues jda_pkg::t_dp_cmd strobes to jda_datapath and reads its status.
`default_nettype none

module jda_ctrl #(
    parameter int MAX_CONSTITUENTS = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_mode,
    input  wire logic              i_last,
    input  wire jda_pkg::t_dp_stat i_stat,
    output jda_pkg::t_dp_cmd       o_cmd,
    output logic                   o_in_stall
);

    localparam int CW = $clog2(MAX_CONSTITUENTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_PROD, S_SUM, S_SEL, S_CSQ, S_DIVI, S_DIV,
        S_WMUL, S_ACC, S_FMUL, S_FSUM, S_FDI, S_FDIV, S_EMIT
    } t_state;

    t_state      r_state;
    logic [CW-1:0] r_cnt;
    logic [5:0]  r_step;
    logic        r_last;
    logic        r_take;
    logic        accept;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_ax1  = accept && i_mode == jda_pkg::MODE_AXIS_ONE;
        o_cmd.load_ax2  = accept && i_mode == jda_pkg::MODE_AXIS_TWO;
        o_cmd.capture   = accept && i_mode == jda_pkg::MODE_CONST;
        o_cmd.calc_diff = r_state == S_DIFF;
        o_cmd.calc_prod = r_state == S_PROD;
        o_cmd.calc_sum  = r_state == S_SUM;
        o_cmd.calc_sel  = r_state == S_SEL;
        o_cmd.calc_csq  = r_state == S_CSQ;
        o_cmd.div_init  = r_state == S_DIVI;
        o_cmd.div_step  = r_state == S_DIV;
        o_cmd.calc_wmul = r_state == S_WMUL;
        o_cmd.acc_add   = r_state == S_ACC && r_take;
        o_cmd.fin_mul   = r_state == S_FMUL;
        o_cmd.fin_sum   = r_state == S_FSUM;
        o_cmd.fdiv_init = r_state == S_FDI;
        o_cmd.fdiv_step = r_state == S_FDIV;
        o_cmd.out_load  = r_state == S_EMIT && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_last  <= 1'b0;
            r_take  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_last  <= i_last;
                        r_take  <= r_cnt < CW'(MAX_CONSTITUENTS);
                        // drop constituents past the limit, keep the count pinned
                        if (r_cnt < CW'(MAX_CONSTITUENTS)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: r_state <= S_PROD;
                S_PROD: r_state <= S_SUM;
                S_SUM:  r_state <= S_SEL;
                S_SEL: begin
                    r_state <= (i_stat.branch == jda_pkg::BR_PERP) ? S_CSQ : S_WMUL;
                end
                S_CSQ:  r_state <= S_DIVI;
                S_DIVI: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 6'(jda_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_WMUL;
                    end
                end
                S_WMUL: r_state <= S_ACC;
                S_ACC:  r_state <= r_last ? S_FMUL : S_IDLE;
                S_FMUL: r_state <= S_FSUM;
                S_FSUM: r_state <= S_FDI;
                S_FDI: begin
                    r_step  <= '0;
                    r_state <= S_FDIV;
                end
                S_FDIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 6'(jda_pkg::FDIV_STEPS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold until the output register frees up
                    if (i_stat.out_free) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/jet_dipolarity_accumulator.sv]
// jet_dipolarity_accumulator: top level, joins jda_ctrl and jda_datapath.
// Depends on jda_pkg, jda_ctrl and jda_datapath.
`default_nettype none

// Axis loads (mode 0/1) are taken in the idle state, which stays ready for the
// next transaction. A constituent stalls input from the diff to the accumulate
// state; if it projects onto the axis segment, a 34-step restoring divider
// forms the perpendicular distance. A constituent flagged last adds the
// partial-product denominator and a 24-step divider, then waits in the output
// register if the consumer stalls; one result may sit in the output register
// while new transactions are accepted. Constituents past MAX_CONSTITUENTS in a
// jet add nothing. Result is in 2^-16 units, saturating at 2^24-1.
module jet_dipolarity_accumulator #(
    parameter int MAX_CONSTITUENTS = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_mode,
    input  wire logic signed [15:0] i_eta,
    input  wire logic signed [14:0] i_phi,
    input  wire logic [19:0]        i_pt,
    input  wire logic               i_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [23:0]             o_dipolarity_value,
    output logic [1:0]              o_status
);

    jda_pkg::t_dp_cmd  cmd;
    jda_pkg::t_dp_stat stat;

    jda_ctrl #(
        .MAX_CONSTITUENTS(MAX_CONSTITUENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_last     (i_last),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    jda_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_eta              (i_eta),
        .i_phi              (i_phi),
        .i_pt               (i_pt),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_dipolarity_value (o_dipolarity_value),
        .o_status           (o_status)
    );

endmodule

`default_nettype wire
